// File: sv/bf3_pkg.sv
`default_nettype none

package bf3_pkg;

    // Window geometry. The filter is the 3x3 mean: radius one, two line buffers.
    localparam int RADIUS   = 1;
    localparam int SPAN     = 2 * RADIUS + 1;
    localparam int NLINES   = 2 * RADIUS;
    localparam int WIN_SIZE = SPAN * SPAN;

    // Pixel and sum widths.
    localparam int PIX_W     = 8;
    localparam int COL_SUM_W = PIX_W + $clog2(SPAN + 1);
    localparam int SUM_W     = PIX_W + $clog2(WIN_SIZE + 1);

    // Division by the window size as a multiply by a rounded-up reciprocal.
    // The error stays below one output step for every sum under 2^(DIV_SHIFT-1).
    localparam int DIV_SHIFT = 16;
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + WIN_SIZE - 1) / WIN_SIZE;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);

    // Frame geometry limits.
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = SPAN;
    localparam int ROW_W         = 12;
    localparam int HEIGHT_W      = 13;
    localparam int WIDTH_W       = 11;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;

    // Reset values of the configuration registers.
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Per-item control flags that travel down the pipeline.
    typedef struct packed {
        logic emit;      // item produces a result
        logic interior;  // result is the window mean, else zero
        logic last;      // final result of the frame
    } item_flags_t;

endpackage

`default_nettype wire

// File: sv/box_filter_3x3_core.sv
`default_nettype none

// 3x3 box (mean) filter for 8-bit grayscale pixels in raster order. One pixel
// is taken per clock when the output side keeps up; the result offered for a
// pixel is for the position one row up and one column to the left, and the
// last row and column of a frame give no result. Border results are 0. The two
// previous rows sit in one line memory, one word per column holding both rows,
// read when a pixel is taken and written back when that pixel leaves the first
// stage; consecutive pixels always address different columns, so no forwarding
// is needed. The memory needs no clearing after reset. Write image_width and
// image_height only while the block is idle; values outside [3, MAX_WIDTH] and
// [3, 4096] saturate.
module box_filter_3x3_core #(
    parameter int MAX_WIDTH = bf3_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [bf3_pkg::PIX_W-1:0]          in_pixel,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [bf3_pkg::PIX_W-1:0]          out_pixel,
    output logic                                    out_last,
    input  wire logic                               cfg_write_en,
    input  wire logic [bf3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bf3_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import bf3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W = (WMAX_W > WIDTH_W) ? WMAX_W : WIDTH_W;
    localparam int LINE_W = NLINES * PIX_W;
    localparam int PROD_W = SUM_W + RECIP_W;

    // Configuration registers.
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;

    // Raster counters.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    // Line memory and its registered read port.
    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;
    logic [LINE_W-1:0] wr_data;

    // Pipeline stage registers.
    logic                 p1_valid_reg;
    logic [PIX_W-1:0]     p1_pixel_reg;
    logic [COL_W-1:0]     p1_col_reg;
    item_flags_t          p1_flags_reg;
    logic                 p2_valid_reg;
    item_flags_t          p2_flags_reg;
    logic                 p3_valid_reg;
    item_flags_t          p3_flags_reg;
    logic [SUM_W-1:0]     p3_sum_reg;
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     out_pixel_reg;
    logic                 out_last_reg;

    // Column sums of the window, oldest column first.
    logic [COL_SUM_W-1:0] col_sum_reg [SPAN];
    logic [COL_SUM_W-1:0] col_sum_new;
    logic [SUM_W-1:0]     win_sum;
    logic [PROD_W-1:0]    product;

    // Stage enables and the accept strobe.
    logic        en_out;
    logic        en3;
    logic        en2;
    logic        en1;
    logic        accept;
    logic        p1_move;

    // Effective geometry and raster decode.
    logic [WCMP_W-1:0]   width_ext;
    logic [WCMP_W-1:0]   width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic [WCMP_W-1:0]   col_plus1;
    logic [HEIGHT_W-1:0] row_plus1;
    logic                col_wrap;
    logic                row_wrap;
    item_flags_t         in_flags;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_W'(RESET_WIDTH);
            image_height_reg <= HEIGHT_W'(RESET_HEIGHT);
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the frame size to the supported range.
    always_comb
    begin
        width_ext = WCMP_W'(image_width_reg);
        if (width_ext < WCMP_W'(MIN_DIM))
            width_eff = WCMP_W'(MIN_DIM);
        else if (width_ext > WCMP_W'(MAX_WIDTH))
            width_eff = WCMP_W'(MAX_WIDTH);
        else
            width_eff = width_ext;

        if (image_height_reg < HEIGHT_W'(MIN_DIM))
            height_eff = HEIGHT_W'(MIN_DIM);
        else if (image_height_reg > HEIGHT_W'(MAX_HEIGHT))
            height_eff = HEIGHT_W'(MAX_HEIGHT);
        else
            height_eff = image_height_reg;
    end

    // Raster position decode for the incoming item.
    always_comb
    begin
        col_plus1 = WCMP_W'(col_reg) + WCMP_W'(1);
        row_plus1 = HEIGHT_W'(row_reg) + HEIGHT_W'(1);
        col_wrap  = (col_plus1 >= width_eff);
        row_wrap  = (row_plus1 >= height_eff);

        in_flags.emit     = (row_reg >= ROW_W'(RADIUS)) && (col_reg >= COL_W'(RADIUS));
        in_flags.interior = (row_reg >= ROW_W'(NLINES)) && (col_reg >= COL_W'(NLINES));
        in_flags.last     = col_wrap && row_wrap;

        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_plus1[ROW_W-1:0];
        end
        else
        begin
            col_next = col_plus1[COL_W-1:0];
        end
    end

    // Stage enables: a stage moves when the next one is empty or moving.
    assign en_out   = !out_valid_reg || !out_stall;
    assign en3      = !p3_valid_reg || en_out;
    assign en2      = !p2_valid_reg || en3;
    assign en1      = !p1_valid_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;
    assign p1_move  = p1_valid_reg && en2;

    // Raster counters advance on every taken item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line memory: read at the column of a taken item, written back when
    // that item leaves the first stage. The oldest row sits in the low byte.
    assign wr_data = {p1_pixel_reg, rd_data_reg[LINE_W-1:PIX_W]};

    always_ff @(posedge clk)
    begin
        if (p1_move)
            line_mem[p1_col_reg] <= wr_data;
        if (accept)
            rd_data_reg <= line_mem[col_reg];
    end

    // Stage 1 holds the item while its line word is read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en1)
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_pixel_reg <= in_pixel;
            p1_col_reg   <= col_reg;
            p1_flags_reg <= in_flags;
        end
    end

    // Sum of the new window column.
    always_comb
    begin
        col_sum_new = COL_SUM_W'(p1_pixel_reg);
        for (int i = 0; i < NLINES; i++)
            col_sum_new = col_sum_new + COL_SUM_W'(rd_data_reg[i*PIX_W +: PIX_W]);
    end

    // Window column sums shift left as each item leaves stage 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SPAN; i++)
                col_sum_reg[i] <= '0;
        end
        else if (p1_move)
        begin
            for (int i = 0; i < SPAN - 1; i++)
                col_sum_reg[i] <= col_sum_reg[i+1];
            col_sum_reg[SPAN-1] <= col_sum_new;
        end
    end

    // Stage 2 holds the item while the window sum is formed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en2)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p1_move)
            p2_flags_reg <= p1_flags_reg;
    end

    always_comb
    begin
        win_sum = '0;
        for (int i = 0; i < SPAN; i++)
            win_sum = win_sum + SUM_W'(col_sum_reg[i]);
    end

    // Stage 3 holds the window sum for the reciprocal multiply.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (en3)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg && en3)
        begin
            p3_flags_reg <= p2_flags_reg;
            p3_sum_reg   <= win_sum;
        end
    end

    assign product = PROD_W'(p3_sum_reg) * PROD_W'(DIV_RECIP);

    // Output register; items that give no result leave as bubbles.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= p3_valid_reg && p3_flags_reg.emit;
    end

    always_ff @(posedge clk)
    begin
        if (p3_valid_reg && en_out)
        begin
            out_pixel_reg <= p3_flags_reg.interior ? product[DIV_SHIFT +: PIX_W] : '0;
            out_last_reg  <= p3_flags_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: sv/bf3_checker.sv
`default_nettype none

module bf3_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_pixel,
    input wire logic       out_last
);

    // Set once the last item of a frame is taken, cleared by the next one.
    logic after_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            after_last_reg <= 1'b0;
        else if (out_valid && !out_stall)
            after_last_reg <= out_last;
    end

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(out_last))
        else $error("stalled output item changed or was withdrawn");

    // The input side only stalls while a finished result is held back.
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output item");

    // The first result of a new frame lies on the border and is zero.
    a_frame_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && after_last_reg |-> out_pixel == 8'd0 && !out_last)
        else $error("first item after frame end is not a zero border item");

    // The input side is never stalled right after reset.
    a_reset_ready: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_stall)
        else $error("input stalled right after reset");

endmodule

bind box_filter_3x3_core bf3_checker u_bf3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel),
    .out_last  (out_last)
);

`default_nettype wire

// File: sim/bf3_result_checker.sv
`default_nettype none

// Watches both item channels and the register port of the 3x3 mean filter.
// It keeps its own copy of the raster state and predicts each result, then
// compares every accepted result with the oldest prediction.
module bf3_result_checker #(
    parameter int MAX_WIDTH = bf3_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic [bf3_pkg::PIX_W-1:0]          in_pixel,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic [bf3_pkg::PIX_W-1:0]          out_pixel,
    input  wire logic                               out_last,
    input  wire logic                               cfg_write_en,
    input  wire logic [bf3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bf3_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                      mismatches,
    output int                                      pending
);

    import bf3_pkg::*;

    localparam int PRINT_CAP = 30;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } mean_result_t;

    // Predicted filter state.
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0]    line_rows [0:NLINES*MAX_WIDTH-1];
    logic [PIX_W-1:0]    window [0:WIN_SIZE-1];
    int unsigned         row_pos;
    int unsigned         col_pos;
    mean_result_t        expected_means[$];

    // One line per mismatch, capped so a broken block cannot flood the log.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
        begin
            $display("mismatch: %s: got %0d, expected %0d", what, got, want);
        end
        mismatches = mismatches + 1;
    endtask

    // Advance the raster state by one pixel and queue the mean it causes, if any.
    task automatic predict_pixel(input logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      sum;
        int               i;
        int               j;
        logic [PIX_W-1:0] column [0:SPAN-1];
        logic             is_last;
        mean_result_t     res;

        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_reg;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        c = col_pos % MAX_WIDTH;

        // New window column: the older rows from the line buffers, then the pixel.
        for (i = 0; i < NLINES; i++)
        begin
            column[i] = line_rows[i * MAX_WIDTH + c];
        end
        column[NLINES] = pix;
        for (i = 0; i < NLINES; i++)
        begin
            line_rows[i * MAX_WIDTH + c] = column[i + 1];
        end

        // Shift the window left by one column.
        for (i = 0; i < SPAN; i++)
        begin
            for (j = 0; j < SPAN - 1; j++)
            begin
                window[i * SPAN + j] = window[i * SPAN + j + 1];
            end
            window[i * SPAN + SPAN - 1] = column[i];
        end

        is_last = (col_pos + 1 >= w) && (row_pos + 1 >= h);

        // Positions on the border give zero; the rest give the truncated mean.
        if (row_pos >= RADIUS && c >= RADIUS)
        begin
            sum = 0;
            if (row_pos >= NLINES && c >= NLINES)
            begin
                for (i = 0; i < WIN_SIZE; i++)
                begin
                    sum = sum + window[i];
                end
            end
            res.pixel = PIX_W'(sum / WIN_SIZE);
            res.last  = is_last;
            expected_means.push_back(res);
        end

        col_pos = col_pos + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = row_pos + 1;
            if (row_pos >= h)
            begin
                row_pos = 0;
            end
        end
    endtask

    // Compare one accepted result with the oldest prediction.
    task automatic check_result();
        mean_result_t want;

        if (expected_means.size() == 0)
        begin
            report_mismatch("result with no pixel waiting for it", out_pixel, -1);
        end
        else
        begin
            want = expected_means.pop_front();
            if (out_pixel !== want.pixel)
            begin
                report_mismatch("out_pixel", out_pixel, want.pixel);
            end
            if (out_last !== want.last)
            begin
                report_mismatch("out_last", out_last, want.last);
            end
        end
    endtask

    // Results are checked before the new pixel is predicted; they never depend on it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_W'(RESET_WIDTH);
            height_reg = HEIGHT_W'(RESET_HEIGHT);
            row_pos    = 0;
            col_pos    = 0;
            mismatches = 0;
            for (int k = 0; k < WIN_SIZE; k++)
            begin
                window[k] = '0;
            end
            for (int k = 0; k < NLINES * MAX_WIDTH; k++)
            begin
                line_rows[k] = '0;
            end
            expected_means.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                check_result();
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                predict_pixel(in_pixel);
            end
            if (cfg_write_en === 1'b1)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                begin
                    width_reg = cfg_data[WIDTH_W-1:0];
                end
                else if (cfg_index == REG_IMAGE_HEIGHT)
                begin
                    height_reg = cfg_data[HEIGHT_W-1:0];
                end
            end
            pending <= expected_means.size();
        end
    end

endmodule

`default_nettype wire

// File: sim/box_filter_3x3_core_test.sv
`default_nettype none

module box_filter_3x3_core_test;

    import bf3_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int RANDOM_PIXELS = 1020;
    localparam int SIZE_SLACK    = 60;

    typedef enum int {
        PIX_MIXED,
        PIX_UNIFORM,
        PIX_ALL_HIGH,
        PIX_ALL_LOW,
        PIX_NEAR_HIGH,
        PIX_NEAR_LOW,
        PIX_CHECKER
    } pix_fill_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [PIX_W-1:0]       in_pixel     = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [PIX_W-1:0]       out_pixel;
    logic                   out_last;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    int mismatches;
    int pending;
    int cycle_count  = 0;
    int pixels_sent  = 0;
    int frames_sent  = 0;
    int geometries   = 0;
    int gap_calm     = 0;
    int stall_run    = 0;
    int free_run     = 0;

    box_filter_3x3_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_pixel     (in_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_pixel    (out_pixel),
        .out_last     (out_last),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bf3_result_checker #(
        .MAX_WIDTH (DEF_MAX_WIDTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_pixel     (in_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_pixel    (out_pixel),
        .out_last     (out_last),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Clock with a period of eight units.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output back-pressure: short stalls mostly, a few long ones, and calm stretches.
    always @(negedge clk)
    begin
        int roll;

        if (stall_run == 0 && free_run == 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                free_run = $urandom_range(30, 120);
            else if (roll < 60)
                free_run = $urandom_range(1, 4);
            else if (roll < 93)
                stall_run = $urandom_range(1, 3);
            else
                stall_run = $urandom_range(6, 40);
        end
        if (stall_run != 0)
        begin
            out_stall <= 1'b1;
            stall_run = stall_run - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            free_run = free_run - 1;
        end
    end

    function automatic int clamp_extent(input int v, input int hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Idle cycles before the next item: mostly none or a few, now and then many.
    function automatic int pick_gap();
        int roll;

        if (gap_calm > 0)
        begin
            gap_calm = gap_calm - 1;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            gap_calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one pixel item and return at the falling edge after it is taken.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;

        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_pixel <= pix;
        do @(posedge clk); while (in_stall !== 1'b0);
        @(negedge clk);
        pixels_sent = pixels_sent + 1;
    endtask

    // Stop sending until every predicted mean has come back.
    task automatic hold_for_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // Both registers are written on consecutive cycles with the enable held high.
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] raw_w,
                                input logic [CFG_DATA_W-1:0] raw_h);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_IMAGE_WIDTH;
        cfg_data     <= raw_w;
        @(negedge clk);
        cfg_index    <= REG_IMAGE_HEIGHT;
        cfg_data     <= raw_h;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // One whole frame in raster order; hold_at names a pixel to pause before.
    task automatic send_frame(input int w, input int h, input pix_fill_t fill,
                              input int hold_at);
        int        r;
        int        c;
        int        k;
        int        roll;
        pix_fill_t kind;
        logic [PIX_W-1:0] pix;

        kind = fill;
        if (kind == PIX_MIXED)
        begin
            roll = $urandom_range(0, 19);
            case (roll)
                0:       kind = PIX_ALL_HIGH;
                1:       kind = PIX_ALL_LOW;
                2:       kind = PIX_NEAR_HIGH;
                3:       kind = PIX_NEAR_LOW;
                4:       kind = PIX_CHECKER;
                default: kind = PIX_UNIFORM;
            endcase
        end
        k = 0;
        for (r = 0; r < h; r++)
        begin
            for (c = 0; c < w; c++)
            begin
                if (k == hold_at)
                begin
                    hold_for_results();
                end
                case (kind)
                    PIX_ALL_HIGH:  pix = '1;
                    PIX_ALL_LOW:   pix = '0;
                    PIX_NEAR_HIGH: pix = PIX_W'($urandom_range(250, 255));
                    PIX_NEAR_LOW:  pix = PIX_W'($urandom_range(0, 5));
                    PIX_CHECKER:   pix = ((r + c) % 2 == 1) ? '1 : '0;
                    default:       pix = PIX_W'($urandom_range(0, 255));
                endcase
                send_pixel(pix);
                k = k + 1;
            end
        end
        frames_sent = frames_sent + 1;
    endtask

    // Drain every result, then give the pipeline time to empty fully.
    task automatic wait_idle();
        hold_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Set the geometry while idle, stream whole frames, and drain.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] raw_w,
                             input logic [CFG_DATA_W-1:0] raw_h,
                             input int frames, input pix_fill_t fill, input bit hold_once);
        int w;
        int h;
        int f;
        int hold_at;

        set_geometry(raw_w, raw_h);
        w = clamp_extent(int'(raw_w[WIDTH_W-1:0]), DEF_MAX_WIDTH);
        h = clamp_extent(int'(raw_h[HEIGHT_W-1:0]), MAX_HEIGHT);
        hold_at = hold_once ? $urandom_range(w + 1, w * h - 1) : -1;
        for (f = 0; f < frames; f++)
        begin
            send_frame(w, h, fill, (f == 0) ? hold_at : -1);
        end
        wait_idle();
        geometries = geometries + 1;
    endtask

    initial
    begin
        int               roll;
        int               target;
        int               frames;
        int               frame_pixels;
        bit               held;
        logic [CFG_DATA_W-1:0] raw_w;
        logic [CFG_DATA_W-1:0] raw_h;

        held = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: smallest frame of full-scale pixels, then register values
        // below the minimum, which saturate to 3x3, with a 0/255 checkerboard.
        run_phase(13'd3, 13'd3, 1, PIX_ALL_HIGH, 1'b0);
        run_phase(13'd0, 13'd0, 1, PIX_CHECKER, 1'b0);

        // Random geometries, mostly small frames so that borders come often.
        target = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                raw_w = CFG_DATA_W'($urandom_range(3, 12));
            else if (roll < 82)
                raw_w = CFG_DATA_W'($urandom_range(13, 40));
            else if (roll < 92)
                raw_w = CFG_DATA_W'($urandom_range(0, 2));
            else
                raw_w = CFG_DATA_W'($urandom_range(41, 100));
            roll = $urandom_range(0, 99);
            if (roll < 75)
                raw_h = CFG_DATA_W'($urandom_range(3, 8));
            else if (roll < 88)
                raw_h = CFG_DATA_W'($urandom_range(0, 2));
            else
                raw_h = CFG_DATA_W'($urandom_range(9, 16));
            frames       = $urandom_range(1, 3);
            frame_pixels = clamp_extent(int'(raw_w[WIDTH_W-1:0]), DEF_MAX_WIDTH)
                         * clamp_extent(int'(raw_h[HEIGHT_W-1:0]), MAX_HEIGHT);

            // Keep the total near the planned count: fewer frames, or a new draw.
            if (pixels_sent + frames * frame_pixels > target + SIZE_SLACK)
                frames = 1;
            if (pixels_sent + frame_pixels > target + SIZE_SLACK)
                continue;
            run_phase(raw_w, raw_h, frames, PIX_MIXED, !held);
            held = 1'b1;
        end

        // The width register keeps only its own bits of the write data.
        run_phase(13'h1805, 13'd4, 2, PIX_MIXED, 1'b0);

        $display("covered %0d pixels in %0d frames over %0d geometries, from 3x3 up to",
                 pixels_sent, frames_sent, geometries);
        $display("100 wide and 16 high, with random input gaps and output stalls");
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
